>>> hw/rtl/yrp_pkg.sv
// shared types and constants for the yaw-rate pid controller
// no dependencies
`default_nettype none
package yrp_pkg;

	localparam int unsigned RateW  = 24;
	localparam int unsigned ErrW   = 25;
	localparam int unsigned DtW    = 16;
	localparam int unsigned GainW  = 24;
	localparam int unsigned AccW   = 32;
	localparam int unsigned OpW    = 33;
	localparam int unsigned ProdW  = 57;
	localparam int unsigned SumW   = 59;
	localparam int unsigned QuoW   = 41;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 32;

	typedef enum logic [2:0] {
		REG_PROP_GAIN  = 3'd0,
		REG_INTEG_GAIN = 3'd1,
		REG_DERIV_GAIN = 3'd2,
		REG_DEADBAND   = 3'd3,
		REG_INT_LIMIT  = 3'd4,
		REG_MOM_LIMIT  = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_DIV,
		ST_MUL_INC,
		ST_CAND,
		ST_MUL_P,
		ST_MUL_D,
		ST_MUL_IN,
		ST_MUL_IO,
		ST_SUM,
		ST_DEC,
		ST_OUT,
		ST_REJ
	} state_t;

endpackage
`default_nettype wire

>>> hw/rtl/yaw_rate_pid_antiwindup.sv
// yaw-rate pid controller with conditional-integration anti-windup, top level
// sequencer, registers and state; uses yrp_pkg, yrp_serial_div, yrp_serial_mul
//
// channel  direction  handshake            payload
// in       sink       in_valid/in_stall    desired_rate, measured_rate, step_time
// out      source     out_valid/out_stall  yaw_moment, rejected
// cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a beat runs through the error, the serial divider (derivative) and five serial
// multiplies, one after another; the next beat is taken only after its result has
// gone to the output register. a rejected beat skips that work and only waits for
// the output slot.
// reset clears config, state and control; in_stall is high while a beat is
// in work, and the result waits in the output register while out_stall is high.
`default_nettype none
module yaw_rate_pid_antiwindup
	import yrp_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic signed [RateW-1:0]  desired_rate,
	input  wire logic signed [RateW-1:0]  measured_rate,
	input  wire logic [DtW-1:0]           step_time,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [31:0]            yaw_moment,
	output logic                          rejected,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CfgIdxW-1:0]       cfg_index,
	input  wire logic [CfgDataW-1:0]      cfg_data
);

	state_t state_q, state_d;

	logic [GainW-1:0] prop_gain_q, integ_gain_q, deriv_gain_q;
	logic [22:0]      deadband_q;
	logic [30:0]      int_limit_q, mom_limit_q;

	logic signed [RateW-1:0] last_meas_q;
	logic                    have_prev_q;
	logic signed [AccW-1:0]  integ_q;

	logic signed [RateW-1:0] des_q, meas_q;
	logic [DtW-1:0]          dt_q;
	logic signed [ErrW-1:0]  err_q;
	logic                    diff_pos_q;
	logic signed [AccW-1:0]  deriv_q;
	logic signed [AccW-1:0]  cand_q;
	logic signed [33:0]      cand_wide_q;
	logic signed [SumW-1:0]  base_q, p_new_q, p_old_q, s_new_q, s_old_q;
	logic signed [31:0]      result_q;
	logic signed [31:0]      out_moment_q;
	logic                    out_rej_q;
	logic                    out_valid_q;

	logic                    mul_start, mul_done, div_start, div_done;
	logic signed [OpW-1:0]   mul_a;
	logic [GainW-1:0]        mul_b;
	logic signed [ProdW-1:0] mul_p;
	logic [QuoW-1:0]         quo;
	logic [QuoW-1:0]         dividend;

	logic in_acc, slot_free, in_rej;
	logic signed [ErrW-1:0] e_raw, db_ext, d_raw;
	logic [ErrW-1:0]        d_mag;
	logic signed [33:0]     lim34;
	logic signed [42:0]     c_new, c_sel, mlim43;
	logic                   sat_hi, sat_lo, take_new;

	assign in_acc    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign in_rej    = (step_time == '0) || (mom_limit_q == '0);
	assign cfg_ready = 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (in_acc) state_d = in_rej ? ST_REJ : ST_ERR;
			ST_ERR:     state_d = ST_DIV;
			ST_DIV:     if (div_done) state_d = ST_MUL_INC;
			ST_MUL_INC: if (mul_done) state_d = ST_CAND;
			ST_CAND:    state_d = ST_MUL_P;
			ST_MUL_P:   if (mul_done) state_d = ST_MUL_D;
			ST_MUL_D:   if (mul_done) state_d = ST_MUL_IN;
			ST_MUL_IN:  if (mul_done) state_d = ST_MUL_IO;
			ST_MUL_IO:  if (mul_done) state_d = ST_SUM;
			ST_SUM:     state_d = ST_DEC;
			ST_DEC:     state_d = ST_OUT;
			ST_OUT:     if (slot_free) state_d = ST_IDLE;
			ST_REJ:     if (slot_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer: unit starts and multiplier operands
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		div_start = (state_q == ST_ERR);
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_d)
			ST_MUL_INC: begin
				mul_start = (state_q != ST_MUL_INC);
				mul_a = OpW'(err_q);
				mul_b = GainW'(dt_q);
			end
			ST_MUL_P: begin
				mul_start = (state_q != ST_MUL_P);
				mul_a = OpW'(err_q);
				mul_b = prop_gain_q;
			end
			ST_MUL_D: begin
				mul_start = (state_q != ST_MUL_D);
				mul_a = OpW'(deriv_q);
				mul_b = deriv_gain_q;
			end
			ST_MUL_IN: begin
				mul_start = (state_q != ST_MUL_IN);
				mul_a = OpW'(cand_q);
				mul_b = integ_gain_q;
			end
			ST_MUL_IO: begin
				mul_start = (state_q != ST_MUL_IO);
				mul_a = OpW'(integ_q);
				mul_b = integ_gain_q;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	yrp_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_p)
	);

	yrp_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (dt_q),
		.done     (div_done),
		.quotient (quo)
	);

	// error with deadband and measurement difference
	always_comb begin
		e_raw  = ErrW'(des_q) - ErrW'(meas_q);
		db_ext = ErrW'(deadband_q);
		d_raw  = ErrW'(meas_q) - ErrW'(last_meas_q);
		d_mag  = d_raw[ErrW-1] ? ErrW'(-d_raw) : d_raw;
	end

	// divider loads the scaled difference magnitude while the error is formed
	assign dividend = {d_mag, 16'h0000};

	// saturation decision on the Q23.8 candidate
	always_comb begin
		lim34    = 34'(int_limit_q);
		mlim43   = 43'(mom_limit_q);
		c_new    = s_new_q[SumW-1:16];
		sat_hi   = c_new > mlim43;
		sat_lo   = c_new < -mlim43;
		take_new = (!sat_hi && !sat_lo) || (sat_hi && err_q < 0) || (sat_lo && err_q > 0);
		c_sel    = take_new ? c_new : s_old_q[SumW-1:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			prop_gain_q  <= '0;
			integ_gain_q <= '0;
			deriv_gain_q <= '0;
			deadband_q   <= '0;
			int_limit_q  <= '0;
			mom_limit_q  <= '0;
			last_meas_q  <= '0;
			have_prev_q  <= 1'b0;
			integ_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PROP_GAIN:  prop_gain_q  <= cfg_data[GainW-1:0];
					REG_INTEG_GAIN: integ_gain_q <= cfg_data[GainW-1:0];
					REG_DERIV_GAIN: deriv_gain_q <= cfg_data[GainW-1:0];
					REG_DEADBAND:   deadband_q   <= cfg_data[22:0];
					REG_INT_LIMIT:  int_limit_q  <= cfg_data[30:0];
					REG_MOM_LIMIT:  mom_limit_q  <= cfg_data[30:0];
					default: ;
				endcase
			end
			if ((state_q == ST_OUT || state_q == ST_REJ) && slot_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (state_q == ST_DEC && take_new)
				integ_q <= cand_q;
			if (state_q == ST_OUT && slot_free) begin
				last_meas_q <= meas_q;
				have_prev_q <= 1'b1;
			end
			if (state_q == ST_REJ && slot_free)
				have_prev_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			des_q  <= desired_rate;
			meas_q <= measured_rate;
			dt_q   <= step_time;
		end
		if (state_q == ST_ERR) begin
			if (e_raw > db_ext)
				err_q <= e_raw - db_ext;
			else if (e_raw < -db_ext)
				err_q <= e_raw + db_ext;
			else
				err_q <= '0;
			diff_pos_q <= !d_raw[ErrW-1] && (d_raw != '0);
		end
		if (state_q == ST_DIV && div_done) begin
			if (!have_prev_q)
				deriv_q <= '0;
			else if (diff_pos_q)
				deriv_q <= (quo > QuoW'(33'h0_8000_0000)) ? 32'sh8000_0000 : -$signed(quo[31:0]);
			else
				deriv_q <= (quo > QuoW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(quo[31:0]);
		end
		if (state_q == ST_MUL_INC && mul_done)
			cand_wide_q <= 34'(integ_q) + $signed(mul_p[49:16]);
		if (state_q == ST_CAND) begin
			if (cand_wide_q > lim34)
				cand_q <= lim34[AccW-1:0];
			else if (cand_wide_q < -lim34)
				cand_q <= AccW'(-lim34);
			else
				cand_q <= cand_wide_q[AccW-1:0];
		end
		if (state_q == ST_MUL_P && mul_done)
			base_q <= SumW'(mul_p);
		if (state_q == ST_MUL_D && mul_done)
			base_q <= base_q + SumW'(mul_p);
		if (state_q == ST_MUL_IN && mul_done)
			p_new_q <= SumW'(mul_p);
		if (state_q == ST_MUL_IO && mul_done)
			p_old_q <= SumW'(mul_p);
		if (state_q == ST_SUM) begin
			s_new_q <= base_q + p_new_q;
			s_old_q <= base_q + p_old_q;
		end
		if (state_q == ST_DEC) begin
			if (c_sel > mlim43)
				result_q <= mlim43[31:0];
			else if (c_sel < -mlim43)
				result_q <= 32'(-mlim43);
			else
				result_q <= c_sel[31:0];
		end
		if (state_q == ST_OUT && slot_free) begin
			out_moment_q <= result_q;
			out_rej_q    <= 1'b0;
		end
		if (state_q == ST_REJ && slot_free) begin
			out_moment_q <= '0;
			out_rej_q    <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign yaw_moment = out_moment_q;
	assign rejected   = out_rej_q;

endmodule
`default_nettype wire

>>> hw/rtl/yrp_serial_mul.sv
// bit-serial shift-add multiplier: signed operand times unsigned operand
// one bit of the unsigned operand per cycle; uses yrp_pkg
`default_nettype none
module yrp_serial_mul
	import yrp_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [OpW-1:0]   a,
	input  wire logic [GainW-1:0]        b,
	output logic                         done,
	output logic signed [ProdW-1:0]      prod
);

	logic signed [ProdW-1:0] a_q;
	logic signed [ProdW-1:0] acc_q;
	logic [GainW-1:0]        b_q;
	logic [4:0]              cnt_q;
	logic                    busy_q;
	logic                    done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(GainW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= ProdW'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0])
				acc_q <= acc_q + a_q;
			a_q <= a_q <<< 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule
`default_nettype wire

>>> hw/rtl/yrp_serial_div.sv
// restoring divider, one quotient bit per cycle
// unsigned 41-bit dividend over 16-bit divisor; uses yrp_pkg
`default_nettype none
module yrp_serial_div
	import yrp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [QuoW-1:0]    dividend,
	input  wire logic [DtW-1:0]     divisor,
	output logic                    done,
	output logic [QuoW-1:0]         quotient
);

	logic [QuoW-1:0] quo_q;
	logic [DtW-1:0]  rem_q;
	logic [DtW-1:0]  dvs_q;
	logic [5:0]      cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DtW+1:0]  trial;

	// shifted remainder minus divisor, top bit is the borrow
	assign trial = {1'b0, rem_q, quo_q[QuoW-1]} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(QuoW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (trial[DtW+1]) begin
				rem_q <= {rem_q[DtW-2:0], quo_q[QuoW-1]};
				quo_q <= {quo_q[QuoW-2:0], 1'b0};
			end else begin
				rem_q <= trial[DtW-1:0];
				quo_q <= {quo_q[QuoW-2:0], 1'b1};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire
